// ===== src/qos_eng_pkg.sv =====
// ----------------------------------------------------------------------------
// Queue-of-stacks engine package
// Sizes, request and status codes, and the word types of both channels.
// ----------------------------------------------------------------------------
package qos_eng_pkg;

  // Sizing of the element pool, the stack queue and the element data.
  localparam int POOL_DEPTH  = 64;
  localparam int QUEUE_DEPTH = 16;
  localparam int DATA_WIDTH  = 32;

  // Pool address, pool pointer (one extra code for "none"), queue slot, fill.
  localparam int ADDR_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int PTR_W  = $clog2(POOL_DEPTH) + 1;
  localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  // Pointer value that marks the end of a list or an empty stack.
  localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_DEPTH);

  // Request codes.
  localparam logic [2:0] REQ_APPEND    = 3'd0;
  localparam logic [2:0] REQ_DROP      = 3'd1;
  localparam logic [2:0] REQ_PUSH_HEAD = 3'd2;
  localparam logic [2:0] REQ_POP       = 3'd3;
  localparam logic [2:0] REQ_PUSH_TAIL = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_QUEUE_EMPTY = 3'd1;
  localparam logic [2:0] ST_STACK_EMPTY = 3'd2;
  localparam logic [2:0] ST_QUEUE_FULL  = 3'd3;
  localparam logic [2:0] ST_POOL_FULL   = 3'd4;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value_in;
  } qos_eng_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] value_out;
    logic [4:0]         stack_count;
  } qos_eng_out_t;

endpackage

// ===== src/qos_eng_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered (old data is
// returned when the same address is written in the same cycle).
// ----------------------------------------------------------------------------
module qos_eng_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/queue_of_stacks_engine_core.sv =====
// ----------------------------------------------------------------------------
// Queue-of-stacks engine
// A FIFO of stacks whose elements share one linked pool with a free list.
// ----------------------------------------------------------------------------
//
//  channel | ports                      | handshake
//  --------+----------------------------+--------------------------------------
//  request | start, busy, in_word       | taken at an edge with start && !busy
//  result  | out_valid, out_word        | one-cycle strobe, cannot be held off
//
// The engine takes one request in every cycle; busy is always low. The pool
// memories are read at the edge that takes a request, with addresses worked
// out while the request was offered. The next cycle executes the request and
// registers its result in the result register that drives out_valid.
// The feedback loop is the pointer update of the execute stage, which also
// steers the pool reads of the following request.
// Reset is synchronous; no clearing pass is run, because pool entries that
// were never written are recognized by a fresh mark and read as their
// initial free-list link.
//
// Structure
//   Front stage: while a request is offered, its queue slot, the top and bottom
//   of that slot's stack and its pool read addresses are worked out from the
//   state that the request now in the execute stage will leave behind. Table
//   entries and pool words written by that request in the same cycle are
//   forwarded, so no later correction is needed.
//   Execute stage: all status checks and state updates of one request, with at
//   most one write to each table and each pool memory.
//   Result register: holds the result word for its one strobe cycle.
//
// Free list
//   After reset the free list runs 0, 1, 2, ... up to the last entry. Freed
//   entries are always put at its front, so it is always a run of recycled
//   entries followed by the untouched entries from the fresh mark upward. A
//   link read at or above the fresh mark therefore returns address plus one.
// ----------------------------------------------------------------------------
module queue_of_stacks_engine_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  qos_eng_pkg::qos_eng_in_t  in_word,
  output logic                     out_valid,
  output qos_eng_pkg::qos_eng_out_t out_word
);

  localparam int AW = qos_eng_pkg::ADDR_W;
  localparam int PW = qos_eng_pkg::PTR_W;
  localparam int SW = qos_eng_pkg::SLOT_W;
  localparam int CW = qos_eng_pkg::FILL_W;
  localparam int DW = qos_eng_pkg::DATA_WIDTH;

  // Step a queue slot forward or back around the ring.
  function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s == SW'(qos_eng_pkg::QUEUE_DEPTH - 1)) ? '0 : s + SW'(1);
    return r;
  endfunction

  function automatic logic [SW-1:0] slot_prev(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s == '0) ? SW'(qos_eng_pkg::QUEUE_DEPTH - 1) : s - SW'(1);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Architectural state
  // --------------------------------------------------------------------------
  logic [CW-1:0] fill_r, fill_nxt;
  logic [SW-1:0] head_r, head_nxt;
  logic [SW-1:0] tail_r, tail_nxt;
  logic [PW-1:0] free_r, free_nxt;
  logic [PW-1:0] fresh_r, fresh_nxt;

  // Per-slot top and bottom entries; written before they are first read.
  logic [PW-1:0] tops_r [qos_eng_pkg::QUEUE_DEPTH];
  logic [AW-1:0] bots_r [qos_eng_pkg::QUEUE_DEPTH];

  // --------------------------------------------------------------------------
  // Execute stage registers
  // --------------------------------------------------------------------------
  logic          ex_vld_r;
  logic [2:0]    ex_req_r;
  logic [31:0]   ex_val_r;
  logic [SW-1:0] ex_slot_r;
  logic [PW-1:0] ex_top_r;
  logic [AW-1:0] ex_bot_r;
  logic [AW-1:0] lk_addr_r;
  logic          lk_hit_r;
  logic          lk_fresh_r;
  logic [PW-1:0] lk_fwd_r;
  logic          vl_hit_r;
  logic [DW-1:0] vl_fwd_r;

  // Writes issued by the execute stage.
  logic          t_we, b_we, l_we, v_we;
  logic [SW-1:0] t_wa, b_wa;
  logic [PW-1:0] t_wd, l_wd;
  logic [AW-1:0] b_wd, l_wa, v_wa;
  logic [DW-1:0] v_wd;

  logic [2:0]    ex_status;
  logic [DW-1:0] ex_vout;

  // Pool memories.
  logic [AW-1:0] lk_raddr, vl_raddr;
  logic [PW-1:0] lk_q;
  logic [DW-1:0] vl_q;
  logic [PW-1:0] link_rd;
  logic [DW-1:0] val_rd;

  // Front stage.
  logic [SW-1:0] fr_slot;
  logic [PW-1:0] fr_top;
  logic [AW-1:0] fr_bot;
  logic [PW-1:0] fr_lk_addr;

  // Result register.
  logic                      out_valid_r;
  qos_eng_pkg::qos_eng_out_t out_word_r;

  qos_eng_ram #(
    .WIDTH (PW),
    .DEPTH (qos_eng_pkg::POOL_DEPTH)
  ) u_links (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_wa),
    .wdata (l_wd),
    .raddr (lk_raddr),
    .rdata (lk_q)
  );

  qos_eng_ram #(
    .WIDTH (DW),
    .DEPTH (qos_eng_pkg::POOL_DEPTH)
  ) u_values (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_wa),
    .wdata (v_wd),
    .raddr (vl_raddr),
    .rdata (vl_q)
  );

  // A forwarded word wins over the memory; an untouched entry links onward.
  assign link_rd = lk_hit_r   ? lk_fwd_r :
                   lk_fresh_r ? (PW'(lk_addr_r) + PW'(1)) : lk_q;
  assign val_rd  = vl_hit_r ? vl_fwd_r : vl_q;

  // --------------------------------------------------------------------------
  // Execute stage: checks and state updates of one request
  // --------------------------------------------------------------------------
  always_comb begin
    fill_nxt  = fill_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    free_nxt  = free_r;
    fresh_nxt = fresh_r;
    t_we      = 1'b0;
    t_wa      = ex_slot_r;
    t_wd      = qos_eng_pkg::NIL;
    b_we      = 1'b0;
    b_wa      = ex_slot_r;
    b_wd      = free_r[AW-1:0];
    l_we      = 1'b0;
    l_wa      = free_r[AW-1:0];
    l_wd      = ex_top_r;
    v_we      = 1'b0;
    v_wa      = free_r[AW-1:0];
    v_wd      = DW'($unsigned(ex_val_r));
    ex_status = qos_eng_pkg::ST_OK;
    ex_vout   = '0;
    if (ex_vld_r) begin
      unique case (ex_req_r)
        qos_eng_pkg::REQ_APPEND: begin
          if (fill_r == CW'(qos_eng_pkg::QUEUE_DEPTH)) begin
            ex_status = qos_eng_pkg::ST_QUEUE_FULL;
          end else begin
            t_we     = 1'b1;
            t_wa     = tail_r;
            t_wd     = qos_eng_pkg::NIL;
            tail_nxt = slot_next(tail_r);
            fill_nxt = fill_r + CW'(1);
          end
        end
        qos_eng_pkg::REQ_DROP: begin
          if (fill_r == '0) begin
            ex_status = qos_eng_pkg::ST_QUEUE_EMPTY;
          end else begin
            // A non-empty stack is spliced onto the free list as a whole.
            if (ex_top_r != qos_eng_pkg::NIL) begin
              l_we     = 1'b1;
              l_wa     = ex_bot_r;
              l_wd     = free_r;
              free_nxt = ex_top_r;
            end
            t_we     = 1'b1;
            t_wa     = head_r;
            t_wd     = qos_eng_pkg::NIL;
            head_nxt = slot_next(head_r);
            fill_nxt = fill_r - CW'(1);
          end
        end
        qos_eng_pkg::REQ_PUSH_HEAD, qos_eng_pkg::REQ_PUSH_TAIL: begin
          if (fill_r == '0) begin
            ex_status = qos_eng_pkg::ST_QUEUE_EMPTY;
          end else if (free_r == qos_eng_pkg::NIL) begin
            ex_status = qos_eng_pkg::ST_POOL_FULL;
          end else begin
            free_nxt = link_rd;
            v_we     = 1'b1;
            l_we     = 1'b1;
            if (ex_top_r == qos_eng_pkg::NIL) begin
              b_we = 1'b1;
            end
            t_we = 1'b1;
            t_wd = free_r;
            if (free_r == fresh_r) begin
              fresh_nxt = fresh_r + PW'(1);
            end
          end
        end
        qos_eng_pkg::REQ_POP: begin
          if (fill_r == '0) begin
            ex_status = qos_eng_pkg::ST_QUEUE_EMPTY;
          end else if (ex_top_r == qos_eng_pkg::NIL) begin
            ex_status = qos_eng_pkg::ST_STACK_EMPTY;
          end else begin
            ex_vout  = val_rd;
            t_we     = 1'b1;
            t_wd     = link_rd;
            l_we     = 1'b1;
            l_wa     = ex_top_r[AW-1:0];
            l_wd     = free_r;
            free_nxt = ex_top_r;
          end
        end
        default: begin
          // Unknown request codes change nothing and report success.
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Front stage: slot, stack ends and pool read addresses of the next request,
  // taken from the state the executing request leaves behind.
  // --------------------------------------------------------------------------
  always_comb begin
    fr_slot = (in_word.req_type == qos_eng_pkg::REQ_PUSH_TAIL) ?
              slot_prev(tail_nxt) : head_nxt;
    fr_top  = (t_we && (t_wa == fr_slot)) ? t_wd : tops_r[fr_slot];
    fr_bot  = (b_we && (b_wa == fr_slot)) ? b_wd : bots_r[fr_slot];
    if ((in_word.req_type == qos_eng_pkg::REQ_PUSH_HEAD) ||
        (in_word.req_type == qos_eng_pkg::REQ_PUSH_TAIL)) begin
      fr_lk_addr = free_nxt;
    end else begin
      fr_lk_addr = fr_top;
    end
  end

  assign lk_raddr = fr_lk_addr[AW-1:0];
  assign vl_raddr = fr_top[AW-1:0];

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      free_r      <= '0;
      fresh_r     <= '0;
      ex_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_r      <= free_nxt;
      fresh_r     <= fresh_nxt;
      ex_vld_r    <= start;
      out_valid_r <= ex_vld_r;
    end
  end

  // Slot tables and stage payloads carry no reset.
  always_ff @(posedge clk) begin
    if (t_we) begin
      tops_r[t_wa] <= t_wd;
    end
    if (b_we) begin
      bots_r[b_wa] <= b_wd;
    end
    ex_req_r   <= in_word.req_type;
    ex_val_r   <= in_word.value_in;
    ex_slot_r  <= fr_slot;
    ex_top_r   <= fr_top;
    ex_bot_r   <= fr_bot;
    lk_addr_r  <= fr_lk_addr[AW-1:0];
    lk_hit_r   <= l_we && (l_wa == fr_lk_addr[AW-1:0]);
    lk_fresh_r <= (fr_lk_addr >= fresh_nxt);
    lk_fwd_r   <= l_wd;
    vl_hit_r   <= v_we && (v_wa == fr_top[AW-1:0]);
    vl_fwd_r   <= v_wd;
    out_word_r.status      <= ex_status;
    out_word_r.value_out   <= 32'(ex_vout);
    out_word_r.stack_count <= 5'(fill_nxt);
  end

  assign busy      = 1'b0;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    ex_vld_r |=> out_valid_r)
    else $error("executed request produced no result strobe");

  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(qos_eng_pkg::QUEUE_DEPTH))
    else $error("queue fill above its depth");

  a_ring_ends : assert property (@(posedge clk) disable iff (!rst_n)
    ((fill_r == '0) || (fill_r == CW'(qos_eng_pkg::QUEUE_DEPTH))) |->
      (head_r == tail_r))
    else $error("queue head and tail disagree with the fill");

  a_pool_exhausted : assert property (@(posedge clk) disable iff (!rst_n)
    (free_r == qos_eng_pkg::NIL) |-> (fresh_r == qos_eng_pkg::NIL))
    else $error("free list empty while untouched entries remain");

endmodule
